// ===== src/krs_pkg.sv =====
package krs_pkg;

   // window of pending text bytes and the longest letter run one byte can cause
   localparam int unsigned WIN_DEPTH   = 6;
   localparam int unsigned MAX_LETTERS = 6;

   // UTF-8 lead byte of the hiragana block
   localparam logic [7:0] KANA_LEAD = 8'hE3;

   // code point window U+3040 .. U+3093, as the low twelve bits
   localparam logic [11:0] KANA_FIRST = 12'h040;
   localparam logic [11:0] KANA_LAST  = 12'h093;

   // small ya, yu, yo as table indexes
   localparam logic [6:0] SMALL_YA = 7'd67;
   localparam logic [6:0] SMALL_YU = 7'd69;
   localparam logic [6:0] SMALL_YO = 7'd71;

   // padding character of the romaji strings below
   localparam logic [7:0] PAD_CHAR = 8'h20;

   typedef logic [6:0] char_type;

   // up to three letters, ch[0] first
   typedef struct packed {
      logic [1:0]         len;
      char_type [2:0]     ch;
   } romaji_type;

   typedef struct packed {
      logic       ok;
      logic [6:0] idx;
   } kana_type;

   // letters caused by one input byte
   typedef struct packed {
      char_type [MAX_LETTERS-1:0] letters;
      logic [2:0]                 count;
      logic                       is_last;
   } group_type;

   // unpack a three-character string, right padded with spaces
   function automatic romaji_type romaji_of(input logic [23:0] s);
      romaji_type r;
      for (int i = 0; i < 3; i++) begin
         r.ch[i] = (s[23-8*i -: 8] == PAD_CHAR) ? 7'd0 : s[22-8*i -: 7];
      end
      if (s[7:0] != PAD_CHAR) begin
         r.len = 2'd3;
      end else if (s[15:8] != PAD_CHAR) begin
         r.len = 2'd2;
      end else if (s[23:16] != PAD_CHAR) begin
         r.len = 2'd1;
      end else begin
         r.len = 2'd0;
      end
      return r;
   endfunction

   // decode three UTF-8 bytes into a hiragana table index
   function automatic kana_type kana_decode(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2);
      kana_type   k;
      logic [11:0] low;
      low   = {b1[5:0], b2[5:0]};
      k.ok  = (b0 == KANA_LEAD) && (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10) &&
              (low >= KANA_FIRST) && (low <= KANA_LAST);
      k.idx = 7'(low - KANA_FIRST);
      return k;
   endfunction

   // romaji of a single kana
   function automatic romaji_type mono_romaji(input logic [6:0] idx);
      logic [23:0] s;
      case (idx)
         7'd2:  s = "a  ";
         7'd4:  s = "i  ";
         7'd6:  s = "u  ";
         7'd8:  s = "e  ";
         7'd10: s = "o  ";
         7'd11: s = "ka ";
         7'd12: s = "ga ";
         7'd13: s = "ki ";
         7'd14: s = "gi ";
         7'd15: s = "ku ";
         7'd16: s = "gu ";
         7'd17: s = "ke ";
         7'd18: s = "ge ";
         7'd19: s = "ko ";
         7'd20: s = "go ";
         7'd21: s = "sa ";
         7'd22: s = "za ";
         7'd23: s = "si ";
         7'd24: s = "ji ";
         7'd25: s = "su ";
         7'd26: s = "zu ";
         7'd27: s = "se ";
         7'd28: s = "ze ";
         7'd29: s = "so ";
         7'd30: s = "zo ";
         7'd31: s = "ta ";
         7'd32: s = "da ";
         7'd33: s = "ti ";
         7'd34: s = "di ";
         7'd35: s = "t  ";
         7'd36: s = "tsu";
         7'd37: s = "du ";
         7'd38: s = "te ";
         7'd39: s = "de ";
         7'd40: s = "to ";
         7'd41: s = "do ";
         7'd42: s = "na ";
         7'd43: s = "ni ";
         7'd44: s = "nu ";
         7'd45: s = "ne ";
         7'd46: s = "no ";
         7'd47: s = "ha ";
         7'd48: s = "ba ";
         7'd49: s = "pa ";
         7'd50: s = "hi ";
         7'd51: s = "bi ";
         7'd52: s = "pi ";
         7'd53: s = "fu ";
         7'd54: s = "bu ";
         7'd55: s = "pu ";
         7'd56: s = "he ";
         7'd57: s = "be ";
         7'd58: s = "pe ";
         7'd59: s = "ho ";
         7'd60: s = "bo ";
         7'd61: s = "po ";
         7'd62: s = "ma ";
         7'd63: s = "mi ";
         7'd64: s = "mu ";
         7'd65: s = "me ";
         7'd66: s = "mo ";
         7'd68: s = "ya ";
         7'd70: s = "yu ";
         7'd72: s = "yo ";
         7'd73: s = "ra ";
         7'd74: s = "ri ";
         7'd75: s = "ru ";
         7'd76: s = "re ";
         7'd77: s = "ro ";
         7'd79: s = "wa ";
         7'd82: s = "wo ";
         7'd83: s = "n  ";
         default: s = "   ";
      endcase
      return romaji_of(s);
   endfunction

   // consonant part of a yoon pair led by this kana
   function automatic romaji_type yoon_prefix(input logic [6:0] idx);
      logic [23:0] s;
      case (idx)
         7'd13: s = "ky ";
         7'd14: s = "gy ";
         7'd23: s = "sh ";
         7'd24: s = "j  ";
         7'd33: s = "ch ";
         7'd43: s = "ny ";
         7'd50: s = "hy ";
         7'd51: s = "by ";
         7'd52: s = "py ";
         7'd63: s = "my ";
         7'd74: s = "ry ";
         default: s = "   ";
      endcase
      return romaji_of(s);
   endfunction

   // vowel of a small ya, yu or yo
   function automatic romaji_type vowel_of(input logic [6:0] idx);
      logic [23:0] s;
      case (idx)
         SMALL_YA: s = "a  ";
         SMALL_YU: s = "u  ";
         SMALL_YO: s = "o  ";
         default:  s = "   ";
      endcase
      return romaji_of(s);
   endfunction

endpackage

// ===== src/krs_front.sv =====
module krs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [7:0]         in_byte,
   input  logic               is_last,
   output logic               enq,
   output krs_pkg::group_type group
);
   import krs_pkg::*;

   logic [7:0] win_ff [WIN_DEPTH];
   logic [7:0] win_in [WIN_DEPTH];
   logic [2:0] count_ff;
   logic [2:0] count_in;

   logic [7:0] w [WIN_DEPTH];
   logic [2:0] slot;
   logic [2:0] n;
   logic [2:0] total;
   logic [2:0] kk;
   kana_type   ka;
   kana_type   kb;
   romaji_type yp;
   romaji_type pa;
   romaji_type pb;
   logic       pair_ok;
   logic       emit;

   // place the new byte and classify the window
   always_comb begin
      slot = (count_ff >= 3'(WIN_DEPTH)) ? 3'd0 : count_ff;
      n    = slot + 3'd1;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         w[i] = win_ff[i];
      end
      w[slot] = in_byte;

      ka      = kana_decode(w[0], w[1], w[2]);
      kb      = kana_decode(w[3], w[4], w[5]);
      yp      = yoon_prefix(ka.idx);
      pair_ok = (n == 3'(WIN_DEPTH)) && ka.ok && kb.ok && (yp.len != 2'd0) &&
                ((kb.idx == SMALL_YA) || (kb.idx == SMALL_YU) || (kb.idx == SMALL_YO));
      emit    = is_last || (n == 3'(WIN_DEPTH));

      // pick the two romaji pieces
      pa = '0;
      pb = '0;
      if (pair_ok) begin
         pa = yp;
         pb = vowel_of(kb.idx);
      end else begin
         if (ka.ok && (n >= 3'd3)) begin
            pa = mono_romaji(ka.idx);
         end
         if (is_last && kb.ok && (n == 3'(WIN_DEPTH))) begin
            pb = mono_romaji(kb.idx);
         end
      end
      total = 3'(pa.len) + 3'(pb.len);

      // join the pieces into one letter run
      kk = 3'd0;
      for (int k = 0; k < MAX_LETTERS; k++) begin
         kk = 3'(k) - 3'(pa.len);
         if (3'(k) < 3'(pa.len)) begin
            group.letters[k] = pa.ch[2'(k)];
         end else if (kk < 3'd3) begin
            group.letters[k] = pb.ch[kk[1:0]];
         end else begin
            group.letters[k] = 7'd0;
         end
      end
      group.count   = emit ? total : 3'd0;
      group.is_last = is_last;
      enq           = take && (is_last || (emit && (total != 3'd0)));
   end

   // advance the window: clear on end of text or pair, drop the first kana when full, else append
   always_comb begin
      win_in   = win_ff;
      count_in = count_ff;
      if (take) begin
         if (is_last) begin
            count_in = 3'd0;
         end else if (n == 3'(WIN_DEPTH)) begin
            if (pair_ok) begin
               count_in = 3'd0;
            end else begin
               win_in[0] = w[3];
               win_in[1] = w[4];
               win_in[2] = w[5];
               count_in  = 3'd3;
            end
         end else begin
            win_in   = w;
            count_in = n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < 3'(WIN_DEPTH))
      else $error("window count out of range");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      take && is_last |=> count_ff == 3'd0)
      else $error("window not cleared after end of text");
`endif

endmodule

// ===== src/krs_queue.sv =====
module krs_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_en,
   input  krs_pkg::group_type push_group,
   output logic               q_full,
   input  logic               pop_en,
   output krs_pkg::group_type head,
   output logic               q_empty
);
   import krs_pkg::*;

   localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(DEPTH + 1);

   group_type         store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;

   assign q_full  = (fill_ff == FILL_W'(DEPTH));
   assign q_empty = (fill_ff == '0);
   assign head    = store_ff[rd_ptr_ff];

   // advance the pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_en && !pop_en) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop_en && !push_en) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // store the pushed group
   always_ff @(posedge clock) begin
      if (push_en) begin
         store_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

// ===== src/krs_back.sv =====
module krs_back (
   input  logic               clock,
   input  logic               reset,
   input  krs_pkg::group_type head,
   input  logic               q_empty,
   output logic               q_pop,
   input  logic               pop,
   output logic               has_char,
   output logic [6:0]         out_char,
   output logic               last_of_run,
   output logic               end_of_text
);
   import krs_pkg::*;

   logic [2:0] pos_ff;
   logic [2:0] pos_in;
   logic       taken;

   // present the current letter of the head group
   assign has_char    = (head.count != 3'd0);
   assign out_char    = has_char ? head.letters[pos_ff] : 7'd0;
   assign last_of_run = !has_char || (pos_ff == head.count - 3'd1);
   assign end_of_text = last_of_run && head.is_last;
   assign taken       = pop && !q_empty;
   assign q_pop       = taken && last_of_run;

   // step through the group, release it after its final letter
   always_comb begin
      pos_in = pos_ff;
      if (taken) begin
         pos_in = last_of_run ? 3'd0 : pos_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 3'd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

`ifndef SYNTHESIS
   a_pos_in_group: assert property (@(posedge clock) disable iff (reset)
      !q_empty && (head.count != 3'd0) |-> pos_ff < head.count)
      else $error("letter position beyond group");

   a_pos_idle: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> pos_ff == 3'd0)
      else $error("letter position held with no group");
`endif

endmodule

// ===== src/kana_utf8_to_romaji_stream.sv =====
// A byte that releases letters (full window or end of text) shows the first one on the
// rsp ports in the cycle after its transfer, when nothing is queued ahead of it.
// Throughput: one byte per cycle in while full is low; one letter per cycle out while pop
// is high and empty is low, up to six letters per byte, with QUEUE_DEPTH groups buffered
// between classifier and letter sequencer; full rises only at QUEUE_DEPTH queued groups.
// Reset (synchronous): clears window count, queue pointers and fill, letter position only.
module kana_utf8_to_romaji_stream #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_is_last,
   output logic       empty,
   input  logic       pop,
   output logic       rsp_has_char,
   output logic [6:0] rsp_out_char,
   output logic       rsp_last_of_run,
   output logic       rsp_end_of_text
);
   import krs_pkg::*;

   logic      take;
   logic      enq;
   logic      q_full;
   logic      q_empty;
   logic      q_pop;
   group_type group;
   group_type head;

   assign take  = push && !q_full;
   assign full  = q_full;
   assign empty = q_empty;

   krs_front u_front (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .in_byte (req_in_byte),
      .is_last (req_is_last),
      .enq     (enq),
      .group   (group)
   );

   krs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (enq),
      .push_group (group),
      .q_full     (q_full),
      .pop_en     (q_pop),
      .head       (head),
      .q_empty    (q_empty)
   );

   krs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .pop         (pop),
      .has_char    (rsp_has_char),
      .out_char    (rsp_out_char),
      .last_of_run (rsp_last_of_run),
      .end_of_text (rsp_end_of_text)
   );

endmodule
